>>> src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: command and
// status codes, controller states, and the command/status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CMD_W    = 2;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		AS_LAST,
		AS_NEXT,
		AS_FIRST
	} addr_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT,
		S_DRAIN,
		S_PLACE,
		S_SCAN,
		S_SCAN_LAST,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      plan_load;
		status_t   plan_status;
		cnt_op_t   plan_cnt;
		logic      addr_load;
		addr_sel_t addr_sel;
		logic      rd_issue;
		logic      rd_move;
		logic      put_tail;
		logic      put_pos;
		logic      res_load;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic bad_pos;
		logic last_one;
		logic is_empty;
		logic at_end;
		logic hit;
		logic out_free;
	} dp_stat_t;

endpackage

>>> src/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller of the positional list engine: decodes one item, sequences
// the shift or scan walk through the list RAM and hands the result over.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ple_pkg::dp_stat_t  stat,
	output ple_pkg::dp_cmd_t   cmd
);

	import ple_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_APPEND: state_d = S_FINISH;
					CMD_INSERT: begin
						if (stat.bad_pos || stat.full) state_d = S_FINISH;
						else state_d = S_SHIFT;
					end
					CMD_REMOVE: begin
						if (stat.bad_pos || stat.last_one) state_d = S_FINISH;
						else state_d = S_SHIFT;
					end
					CMD_SEARCH: begin
						if (stat.is_empty) state_d = S_FINISH;
						else state_d = S_SCAN;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_SHIFT: begin
				if (stat.at_end) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (stat.cmd == CMD_INSERT) state_d = S_PLACE;
				else state_d = S_FINISH;
			end
			S_PLACE: state_d = S_FINISH;
			S_SCAN: begin
				if (stat.hit) state_d = S_FINISH;
				else if (stat.at_end) state_d = S_SCAN_LAST;
			end
			S_SCAN_LAST: state_d = S_FINISH;
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.plan_status = ST_OK;
		cmd.plan_cnt = CNT_HOLD;
		cmd.addr_sel = AS_FIRST;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_DECODE: begin
				cmd.plan_load = 1'b1;
				unique case (stat.cmd)
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.plan_status = ST_FULL;
						end else begin
							cmd.put_tail = 1'b1;
							cmd.plan_cnt = CNT_INC;
						end
					end
					CMD_INSERT: begin
						if (stat.bad_pos) begin
							cmd.plan_status = ST_BADPOS;
						end else if (stat.full) begin
							cmd.plan_status = ST_FULL;
						end else begin
							cmd.plan_cnt  = CNT_INC;
							cmd.addr_load = 1'b1;
							cmd.addr_sel  = AS_LAST;
						end
					end
					CMD_REMOVE: begin
						if (stat.bad_pos) begin
							cmd.plan_status = ST_BADPOS;
						end else begin
							cmd.plan_cnt  = CNT_DEC;
							cmd.addr_load = !stat.last_one;
							cmd.addr_sel  = AS_NEXT;
						end
					end
					CMD_SEARCH: begin
						cmd.addr_load = !stat.is_empty;
						cmd.addr_sel  = AS_FIRST;
					end
					default: cmd.plan_status = ST_OK;
				endcase
			end
			S_SHIFT: begin
				cmd.rd_issue = 1'b1;
				cmd.rd_move  = 1'b1;
			end
			S_PLACE: cmd.put_pos = 1'b1;
			S_SCAN: cmd.rd_issue = !stat.hit;
			S_FINISH: cmd.res_load = stat.out_free;
			default: cmd.accept = 1'b0;
		endcase
	end

endmodule

>>> src/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp
// Datapath of the positional list engine: item registers, entry count,
// walk address and read pipeline around the list RAM, and result register.
// ----------------------------------------------------------------------------
module ple_dp #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ple_pkg::dp_cmd_t                    cmd,
	output ple_pkg::dp_stat_t                   stat,
	input  logic [ple_pkg::CMD_W-1:0]           command,
	input  logic signed [ple_pkg::VAL_W-1:0]    value,
	input  logic [ple_pkg::POS_W-1:0]           position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ple_pkg::STATUS_W-1:0]        status,
	output logic                                found,
	output logic [ple_pkg::POS_W-1:0]           found_position,
	output logic [ple_pkg::COUNT_W-1:0]         count,
	output logic                                empty_res
);

	import ple_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W + 1) ? CW : POS_W + 1;
	localparam int VW = (VAL_W > DATA_WIDTH) ? VAL_W : DATA_WIDTH;
	localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int FW = (AW > POS_W) ? AW : POS_W;

	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	logic [CW-1:0]         cnt_q;
	status_t               plan_status_q;
	cnt_op_t               plan_cnt_q;
	logic [AW-1:0]         addr_q;
	logic                  found_q;
	logic [AW-1:0]         fpos_q;

	logic                  rd_pend_s1;
	logic                  mv_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic [AW-1:0]         wr_addr_s1;

	logic                  out_valid_q;
	status_t               res_status_q;
	logic                  res_found_q;
	logic [POS_W-1:0]      res_fpos_q;
	logic [COUNT_W-1:0]    res_count_q;
	logic                  res_empty_q;

	logic [VW-1:0]         val_ext;
	logic [PW-1:0]         pos_x;
	logic [PW-1:0]         pos_p1;
	logic [PW-1:0]         cnt_x;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         cnt_next;
	logic [OW-1:0]         cnt_next_x;
	logic [FW-1:0]         fpos_x;
	logic [AW-1:0]         end_addr;
	logic                  walk_down;
	logic                  out_free;
	logic                  hit;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign val_ext    = VW'($unsigned(value));
	assign pos_x      = PW'(pos_q);
	assign pos_p1     = pos_x + PW'(1);
	assign cnt_x      = PW'(cnt_q);
	assign cnt_m1     = cnt_q - CW'(1);
	assign walk_down  = (cmd_q == CMD_INSERT);
	assign end_addr   = walk_down ? pos_x[AW-1:0] : cnt_m1[AW-1:0];
	assign out_free   = !out_valid_q || out_ready;
	assign hit        = rd_pend_s1 && !mv_s1 && (ram_rdata == val_q);
	assign cnt_next_x = OW'(cnt_next);
	assign fpos_x     = FW'(fpos_q);

	always_comb begin
		case (plan_cnt_q)
			CNT_INC: cnt_next = cnt_q + CW'(1);
			CNT_DEC: cnt_next = cnt_m1;
			default: cnt_next = cnt_q;
		endcase
	end

	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = (cnt_q == CW'(DEPTH));
		stat.bad_pos  = (pos_x >= cnt_x);
		stat.last_one = (pos_p1 == cnt_x);
		stat.is_empty = (cnt_q == '0);
		stat.at_end   = (addr_q == end_addr);
		stat.hit      = hit;
		stat.out_free = out_free;
	end

	// moved entries land one read behind the walk; appends and placements
	// never overlap a pending move
	always_comb begin
		ram_we    = (rd_pend_s1 && mv_s1) || cmd.put_tail || cmd.put_pos;
		ram_wdata = val_q;
		if (rd_pend_s1 && mv_s1) begin
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.put_tail) begin
			ram_waddr = cnt_q[AW-1:0];
		end else begin
			ram_waddr = pos_x[AW-1:0];
		end
	end

	ple_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_issue),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q <= cmd_t'(command);
			val_q <= val_ext[DATA_WIDTH-1:0];
			pos_q <= position;
		end
		if (cmd.plan_load) begin
			plan_status_q <= cmd.plan_status;
			plan_cnt_q    <= cmd.plan_cnt;
		end
		if (cmd.addr_load) begin
			case (cmd.addr_sel)
				AS_LAST: addr_q <= cnt_m1[AW-1:0];
				AS_NEXT: addr_q <= pos_p1[AW-1:0];
				default: addr_q <= '0;
			endcase
		end else if (cmd.rd_issue) begin
			addr_q <= walk_down ? addr_q - AW'(1) : addr_q + AW'(1);
		end
		mv_s1      <= cmd.rd_move;
		rd_addr_s1 <= addr_q;
		wr_addr_s1 <= walk_down ? addr_q + AW'(1) : addr_q - AW'(1);
		// keep the first match only
		if (cmd.accept) begin
			found_q <= 1'b0;
			fpos_q  <= '0;
		end else if (hit && !found_q) begin
			found_q <= 1'b1;
			fpos_q  <= rd_addr_s1;
		end
		if (cmd.res_load) begin
			res_status_q <= plan_status_q;
			res_found_q  <= found_q;
			res_fpos_q   <= fpos_x[POS_W-1:0];
			res_count_q  <= cnt_next_x[COUNT_W-1:0];
			res_empty_q  <= (cnt_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_issue;
			if (cmd.res_load) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign found          = res_found_q;
	assign found_position = res_fpos_q;
	assign count          = res_count_q;
	assign empty_res      = res_empty_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.res_load |=> $stable(cnt_q))
		else $error("entry count moved outside result load");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && mv_s1) |-> !(cmd.put_tail || cmd.put_pos))
		else $error("RAM write port claimed twice");

	a_found_search: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && cmd_q != CMD_SEARCH) |-> !found_q)
		else $error("found flag set outside a search");

endmodule

>>> src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH values with append, insert-at, remove-at and
// search commands; one result item per command item.
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   in      | in_valid, in_ready, command, value, position     | in
//   out     | out_valid, out_ready, status, found,             | out
//           | found_position, count, empty_res                 |
//
// Append, rejected commands, remove at the last position and search on an
// empty list need no walk; insert shifts the entries from the position up,
// remove shifts the entries after it down, and search scans from the first
// entry to a hit or the end. One list RAM read per cycle over the entries moved or scanned.
// One item is in work at a time; the next item is taken while the previous
// result still waits in the output register, and its result load holds
// until that register is free. Reset clears the entry count; the list RAM
// needs no clearing.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ple_pkg::CMD_W-1:0]         command,
	input  logic signed [ple_pkg::VAL_W-1:0]  value,
	input  logic [ple_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ple_pkg::STATUS_W-1:0]      status,
	output logic                              found,
	output logic [ple_pkg::POS_W-1:0]         found_position,
	output logic [ple_pkg::COUNT_W-1:0]       count,
	output logic                              empty_res
);

	import ple_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	ple_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.command        (command),
		.value          (value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found          (found),
		.found_position (found_position),
		.count          (count),
		.empty_res      (empty_res)
	);

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional list engine. A shadow list in the
// bench tracks every accepted command item and predicts its reply. Replies
// are matched in order, field by field. Directed tests cover the empty and
// full list, edge positions and duplicate search hits. Random phases follow,
// with the list swept between empty and full under varied sender idling and
// receiver stalling, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int LIST_DEPTH = 64;
	localparam int MAX_GAP    = 40;
	localparam int MAX_PRINTS = 60;

	typedef struct packed {
		status_t          status;
		logic             found;
		logic [POS_W-1:0] found_position;
		logic [COUNT_W-1:0] count;
		logic             empty_res;
	} list_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]      position;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic                  found;
	logic [POS_W-1:0]      found_position;
	logic [COUNT_W-1:0]    count;
	logic                  empty_res;

	// shadow copy of the list
	logic [VAL_W-1:0] shadow_list [LIST_DEPTH];
	int               shadow_len;
	bit               growing;

	list_reply_t replies_due [$];

	int idle_pct;
	int stall_pct;
	int hold_request;
	int hold_left;
	int mismatch_count;
	int reply_index;
	int cmd_seen [4];
	int full_rejects;
	int bad_positions;
	int search_hits;
	int peak_len;

	positional_list_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.value          (value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found          (found),
		.found_position (found_position),
		.count          (count),
		.empty_res      (empty_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// Apply one command to the shadow list and return the reply it must give.
	function automatic list_reply_t list_apply(cmd_t cmd, logic [VAL_W-1:0] val,
			logic [POS_W-1:0] pos);
		list_reply_t r;
		int i;
		r = '0;
		r.status = ST_OK;
		cmd_seen[cmd]++;
		case (cmd)
			CMD_APPEND: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_list[shadow_len] = val;
					shadow_len++;
				end
			end
			CMD_INSERT: begin
				if (int'(pos) >= shadow_len) begin
					r.status = ST_BADPOS;
				end else if (shadow_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > int'(pos); i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[pos] = val;
					shadow_len++;
				end
			end
			CMD_REMOVE: begin
				if (int'(pos) >= shadow_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = int'(pos); i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
				end
			end
			default: begin
				for (i = 0; i < shadow_len; i++) begin
					if (shadow_list[i] == val) begin
						r.found = 1'b1;
						r.found_position = i[POS_W-1:0];
						break;
					end
				end
			end
		endcase
		if (r.status == ST_FULL)
			full_rejects++;
		if (r.status == ST_BADPOS)
			bad_positions++;
		if (r.found)
			search_hits++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
		r.count = shadow_len[COUNT_W-1:0];
		r.empty_res = (shadow_len == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] reply %0d: %s", $realtime, reply_index, what);
		mismatch_count++;
	endtask

	// Offer one item after a random idle gap and hold it until accepted.
	task automatic send_item(input cmd_t cmd, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		command  = cmd;
		value    = val;
		position = pos;
		do @(posedge clk); while (!in_ready);
		replies_due.push_back(list_apply(cmd, val, pos));
	endtask

	function automatic logic [VAL_W-1:0] pick_value(bit for_search);
		int r;
		r = $urandom_range(99);
		if (for_search && shadow_len > 0 && r < 70)
			return shadow_list[$urandom_range(shadow_len - 1)];
		if (r < 40) begin
			case ($urandom_range(7))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'hffff_ffff;
				4: return 32'h0000_0001;
				5: return 32'h5555_aaaa;
				6: return 32'haaaa_5555;
				default: return 32'h0000_0042;
			endcase
		end
		return $urandom;
	endfunction

	// Sweep the list between empty and full; mostly valid positions.
	task automatic send_random_item();
		int   r;
		cmd_t cmd;
		logic [POS_W-1:0] pos;
		if (shadow_len == LIST_DEPTH && $urandom_range(3) == 0)
			growing = 1'b0;
		else if (shadow_len == 0 && $urandom_range(2) == 0)
			growing = 1'b1;
		r = $urandom_range(99);
		if (growing)
			cmd = (r < 40) ? CMD_APPEND : (r < 65) ? CMD_INSERT :
				(r < 80) ? CMD_REMOVE : CMD_SEARCH;
		else
			cmd = (r < 15) ? CMD_APPEND : (r < 30) ? CMD_INSERT :
				(r < 75) ? CMD_REMOVE : CMD_SEARCH;
		if (shadow_len > 0 && $urandom_range(99) < 85)
			pos = POS_W'($urandom_range(shadow_len - 1));
		else
			pos = POS_W'($urandom_range(LIST_DEPTH - 1));
		send_item(cmd, pick_value(cmd == CMD_SEARCH), pos);
	endtask

	task automatic test_empty_list();
		send_item(CMD_REMOVE, 32'd0, 6'd0);
		send_item(CMD_REMOVE, 32'hffff_ffff, 6'd63);
		send_item(CMD_INSERT, 32'd5, 6'd0);
		send_item(CMD_SEARCH, 32'd0, 6'd0);
	endtask

	task automatic test_basic_ops();
		send_item(CMD_APPEND, 32'h8000_0000, 6'd0);
		send_item(CMD_APPEND, 32'h7fff_ffff, 6'd63);
		send_item(CMD_APPEND, 32'h0000_0000, 6'd0);
		send_item(CMD_INSERT, 32'hffff_ffff, 6'd0);
		// insert at the last position moves the last entry up
		send_item(CMD_INSERT, 32'd7, POS_W'(shadow_len - 1));
		send_item(CMD_APPEND, 32'hffff_ffff, 6'd0);
		send_item(CMD_SEARCH, 32'hffff_ffff, 6'd0);
		send_item(CMD_SEARCH, 32'h0000_0000, 6'd0);
		send_item(CMD_SEARCH, 32'd12345, 6'd0);
		send_item(CMD_REMOVE, 32'd0, 6'd0);
		send_item(CMD_REMOVE, 32'd0, POS_W'(shadow_len - 1));
		send_item(CMD_INSERT, 32'd9, POS_W'(shadow_len));
		send_item(CMD_REMOVE, 32'd0, POS_W'(shadow_len));
		send_item(CMD_SEARCH, 32'h7fff_ffff, 6'd0);
	endtask

	task automatic test_full_list();
		while (shadow_len < LIST_DEPTH)
			send_item(CMD_APPEND, $urandom, POS_W'($urandom));
		send_item(CMD_SEARCH, shadow_list[LIST_DEPTH - 1], 6'd0);
		send_item(CMD_APPEND, 32'd1, 6'd0);
		send_item(CMD_INSERT, 32'd2, 6'd63);
		send_item(CMD_INSERT, 32'd3, 6'd0);
		send_item(CMD_REMOVE, 32'd0, 6'd63);
		send_item(CMD_APPEND, 32'h8000_0000, 6'd0);
		growing = 1'b0;
	endtask

	// Hold the receiver off long enough that the engine backs up its input.
	task automatic test_backpressure();
		int n;
		idle_pct  = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_request = 300;
		for (n = 0; n < 20; n++)
			send_random_item();
	endtask

	task automatic test_random(input int idle, input int stall, input int items);
		int n;
		idle_pct  = idle;
		stall_pct = stall;
		for (n = 0; n < items; n++)
			send_random_item();
	endtask

	// reply checker
	initial begin
		list_reply_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("reply with nothing pending");
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							status, want.status));
					if (found !== want.found)
						report_mismatch($sformatf("found %0d, want %0d",
							found, want.found));
					if (found_position !== want.found_position)
						report_mismatch($sformatf("found_position %0d, want %0d",
							found_position, want.found_position));
					if (count !== want.count)
						report_mismatch($sformatf("count %0d, want %0d",
							count, want.count));
					if (empty_res !== want.empty_res)
						report_mismatch($sformatf("empty_res %0d, want %0d",
							empty_res, want.empty_res));
				end
				reply_index++;
			end
		end
	end

	// receiver: random stalls, plus a counted hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		int waited;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = CMD_APPEND;
		value    = '0;
		position = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		mismatch_count = 0;
		reply_index = 0;
		shadow_len = 0;
		peak_len = 0;
		growing = 1'b1;
		full_rejects = 0;
		bad_positions = 0;
		search_hits = 0;
		cmd_seen = '{default: 0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_backpressure();
		test_random(0, 0, 160);
		test_random(75, 0, 160);
		test_random(0, 75, 160);
		test_random(7, 7, 160);

		@(negedge clk);
		in_valid  = 1'b0;
		stall_pct = 0;
		waited = 0;
		while (replies_due.size() > 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));

		$display("ran %0d appends, %0d inserts, %0d removes, %0d searches",
			cmd_seen[CMD_APPEND], cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE],
			cmd_seen[CMD_SEARCH]);
		$display("saw %0d full rejects, %0d bad positions, %0d search hits, peak length %0d",
			full_rejects, bad_positions, search_hits, peak_len);
		if (mismatch_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
src/ple_pkg.sv
src/ple_ram.sv
src/ple_ctrl.sv
src/ple_dp.sv
src/positional_list_engine.sv
test/testbench.sv
